@@ hdl/tpdm_pkg.sv @@
`timescale 1ns / 1ps
// tpdm_pkg.sv: types, formats and codes shared by the PWM duty modulator.
// No dependencies; compile before every other file of the block.
package tpdm_pkg;

	// Command and gain formats
	localparam int CMD_W     = 16;          // alpha/beta, signed Q3.12
	localparam int GAIN_W    = 16;          // 1/Vbus, unsigned Q0.16
	localparam int MUL1_W    = 33;          // 16 x 17 signed products
	localparam int PH_W      = 50;          // phase values, Q44
	localparam int DUTY_W    = 54;          // signed duty arithmetic, Q45
	localparam int DFRAC     = 45;          // fraction bits of a duty
	localparam int DSAT_W    = DFRAC + 1;   // saturated duty, 0 .. 1.0
	localparam int DSPLIT    = 23;          // low half of the duty split
	localparam int MODE_W    = 3;
	localparam int REG_IDX_W = 2;

	// sqrt(3)/2 in Q16
	localparam logic signed [16:0] COS30_Q16 = 17'sd56755;

	localparam logic signed [DUTY_W-1:0] DUTY_ONE  = DUTY_W'(1) <<< DFRAC;
	localparam logic signed [DUTY_W-1:0] DUTY_HALF = DUTY_W'(1) <<< (DFRAC - 1);
	localparam logic [DSAT_W-1:0]        DSAT_ONE  = {1'b1, {DFRAC{1'b0}}};

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd19859;

	// Modulation modes
	typedef enum logic [MODE_W-1:0] {
		MODE_SPWM      = 3'd0,
		MODE_SVPWM     = 3'd1,
		MODE_CLAMP_MAX = 3'd2,
		MODE_CLAMP_MIN = 3'd3,
		MODE_DPWM0     = 3'd4,
		MODE_DPWM1     = 3'd5,
		MODE_DPWM2     = 3'd6,
		MODE_DPWM3     = 3'd7
	} mode_t;

	// Register indexes of the configuration port
	typedef logic [REG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_MODE   = 2'd0;
	localparam reg_idx_t REG_PERIOD = 2'd1;
	localparam reg_idx_t REG_GAIN   = 2'd2;

	// One classified command: three phases and the common-mode offset (Q45)
	typedef struct packed {
		logic signed [PH_W-1:0]   pa;
		logic signed [PH_W-1:0]   pb;
		logic signed [PH_W-1:0]   pc;
		logic signed [DUTY_W-1:0] ofs;
	} duty_job_t;

endpackage

@@ hdl/tpdm_if.sv @@
`timescale 1ns / 1ps
// tpdm_if.sv: valid/ready channel interfaces of the PWM duty modulator.
// Depends on tpdm_pkg for field widths.

// Voltage command channel
interface tpdm_cmd_if;
	logic                              valid;
	logic                              ready;
	logic signed [tpdm_pkg::CMD_W-1:0] alpha_volts;
	logic signed [tpdm_pkg::CMD_W-1:0] beta_volts;

	modport source (output valid, alpha_volts, beta_volts, input ready);
	modport sink (input valid, alpha_volts, beta_volts, output ready);
endinterface

// Compare value channel
interface tpdm_cmp_if #(
	parameter int COMPARE_WIDTH = 16
);
	logic                     valid;
	logic                     ready;
	logic [COMPARE_WIDTH-1:0] compare_a;
	logic [COMPARE_WIDTH-1:0] compare_b;
	logic [COMPARE_WIDTH-1:0] compare_c;
	logic                     clipped;

	modport source (output valid, compare_a, compare_b, compare_c, clipped, input ready);
	modport sink (input valid, compare_a, compare_b, compare_c, clipped, output ready);
endinterface

// Register write channel; DATA_W must cover the compare width
interface tpdm_cfg_if #(
	parameter int DATA_W = 16
);
	logic                      valid;
	logic                      ready;
	logic [tpdm_pkg::REG_IDX_W-1:0] reg_index;
	logic [DATA_W-1:0]         wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

@@ hdl/three_phase_pwm_duty_modulator_top.sv @@
`timescale 1ns / 1ps
// three_phase_pwm_duty_modulator_top.sv: register file and front/queue/back wiring.
// Depends on tpdm_pkg, tpdm_if, tpdm_front, tpdm_queue and tpdm_back.

// Turns one alpha/beta voltage command into three timer compare values for sine,
// space-vector, clamped or discontinuous PWM, chosen by the mode register. The
// block takes one command per clock while the queue has room: the front (bus scaling, inverse
// Clarke, extremes and offset choice) and the back (saturation and scaling by the
// timer period) are both fully pipelined, and a QUEUE_DEPTH-entry queue between
// them lets the front keep accepting while the result sink stalls, until the
// queue is full. Registers are written on the cfg channel, which is always
// ready; write them only while no command is in flight. The cfg data width must
// be at least 16 and at least COMPARE_WIDTH, and the compare channel width must
// equal COMPARE_WIDTH.
module three_phase_pwm_duty_modulator_top #(
	parameter int COMPARE_WIDTH = 16,  // 8 .. 32
	parameter int QUEUE_DEPTH   = 4    // 2 or more
) (
	input  logic       clk,
	input  logic       arst_n,
	tpdm_cmd_if.sink   cmd,
	tpdm_cmp_if.source cmp,
	tpdm_cfg_if.sink   cfg
);

	tpdm_pkg::mode_t                mode_q;
	logic [COMPARE_WIDTH-1:0]       period_q;
	logic [tpdm_pkg::GAIN_W-1:0]    gain_q;

	tpdm_pkg::duty_job_t front_job, back_job;
	logic                front_valid, front_ready;
	logic                back_valid, back_ready;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= tpdm_pkg::MODE_SVPWM;
			period_q <= '1;
			gain_q   <= tpdm_pkg::GAIN_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				tpdm_pkg::REG_MODE:
					mode_q <= tpdm_pkg::mode_t'(cfg.wdata[tpdm_pkg::MODE_W-1:0]);
				tpdm_pkg::REG_PERIOD:
					period_q <= cfg.wdata[COMPARE_WIDTH-1:0];
				tpdm_pkg::REG_GAIN:
					gain_q <= cfg.wdata[tpdm_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	tpdm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.mode      (mode_q),
		.gain      (gain_q),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready)
	);

	tpdm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_job   (front_job),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_job    (back_job),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	tpdm_back #(
		.COMPARE_WIDTH (COMPARE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (back_job),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.period    (period_q),
		.cmp       (cmp)
	);

	a_cmp_le_period: assert property (@(posedge clk) disable iff (!arst_n)
		cmp.valid |-> (cmp.compare_a <= period_q) && (cmp.compare_b <= period_q)
			&& (cmp.compare_c <= period_q))
		else $error("compare value above the timer period");

	a_clamp_max_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmp.valid && (mode_q == tpdm_pkg::MODE_CLAMP_MAX)) |->
			(cmp.compare_a == period_q) || (cmp.compare_b == period_q)
			|| (cmp.compare_c == period_q))
		else $error("max clamp left no phase at full duty");

	a_clamp_min_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmp.valid && (mode_q == tpdm_pkg::MODE_CLAMP_MIN)) |->
			(cmp.compare_a == '0) || (cmp.compare_b == '0) || (cmp.compare_c == '0))
		else $error("min clamp left no phase at zero duty");

endmodule

@@ hdl/tpdm_front.sv @@
`timescale 1ns / 1ps
// tpdm_front.sv: command intake, bus scaling, inverse Clarke and mode classification.
// Depends on tpdm_pkg and tpdm_cmd_if; feeds tpdm_queue.
module tpdm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	tpdm_cmd_if.sink                      cmd,
	input  tpdm_pkg::mode_t               mode,
	input  logic [tpdm_pkg::GAIN_W-1:0]   gain,
	output tpdm_pkg::duty_job_t           job,
	output logic                          job_valid,
	input  logic                          job_ready
);

	localparam int MUL1_W = tpdm_pkg::MUL1_W;
	localparam int PH_W   = tpdm_pkg::PH_W;
	localparam int DUTY_W = tpdm_pkg::DUTY_W;

	function automatic logic signed [PH_W-1:0] max3(input logic signed [PH_W-1:0] x,
		input logic signed [PH_W-1:0] y, input logic signed [PH_W-1:0] z);
		logic signed [PH_W-1:0] m;
		m = (x >= y) ? x : y;
		return (m >= z) ? m : z;
	endfunction

	function automatic logic signed [PH_W-1:0] min3(input logic signed [PH_W-1:0] x,
		input logic signed [PH_W-1:0] y, input logic signed [PH_W-1:0] z);
		logic signed [PH_W-1:0] m;
		m = (x <= y) ? x : y;
		return (m <= z) ? m : z;
	endfunction

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [16:0]       gain_x;
	logic signed [MUL1_W-1:0] al_s1, bg_s1, p_s1, q_s1;
	logic signed [tpdm_pkg::CMD_W-1:0] ra_s1, rb_s1;

	logic signed [MUL1_W-1:0] ha, hb, rot_al, rot_be;
	logic signed [MUL1_W-1:0] al_s2, ral_s2, rbe_s2;
	logic signed [PH_W-1:0]   bc_s2;

	logic signed [PH_W-1:0] pa_s3, pb_s3, va_s3, vb_s3;
	logic signed [PH_W-1:0] pa_s4, pb_s4, pc_s4, va_s4, vb_s4, vc_s4;
	logic signed [PH_W-1:0] pa_s5, pb_s5, pc_s5, mx_s5, mn_s5, vmx_s5, vmn_s5;

	logic signed [DUTY_W-1:0] mxe, mne, sel_sum, ofs_hi, ofs_lo, ofs;

	// The whole front moves unless a finished job waits on a full queue
	assign adv       = !(v_s5 && !job_ready);
	assign cmd.ready = adv;
	assign gain_x    = {1'b0, gain};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= cmd.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Selector command rotated by the mode's angle
	assign ha = MUL1_W'(ra_s1) <<< 15;
	assign hb = MUL1_W'(rb_s1) <<< 15;

	always_comb begin
		unique case (mode)
			tpdm_pkg::MODE_DPWM0: begin
				rot_al = p_s1 - hb;
				rot_be = ha + q_s1;
			end
			tpdm_pkg::MODE_DPWM2: begin
				rot_al = p_s1 + hb;
				rot_be = q_s1 - ha;
			end
			tpdm_pkg::MODE_DPWM3: begin
				rot_al = ha - q_s1;
				rot_be = p_s1 + hb;
			end
			default: begin
				rot_al = '0;
				rot_be = '0;
			end
		endcase
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: bus scaling and rotation products
			al_s1 <= MUL1_W'(cmd.alpha_volts) * MUL1_W'(gain_x);
			bg_s1 <= MUL1_W'(cmd.beta_volts) * MUL1_W'(gain_x);
			p_s1  <= MUL1_W'(cmd.alpha_volts) * MUL1_W'(tpdm_pkg::COS30_Q16);
			q_s1  <= MUL1_W'(cmd.beta_volts) * MUL1_W'(tpdm_pkg::COS30_Q16);
			ra_s1 <= cmd.alpha_volts;
			rb_s1 <= cmd.beta_volts;
			// s2: beta term of phase b, rotated selector command
			al_s2  <= al_s1;
			bc_s2  <= PH_W'(bg_s1) * PH_W'(tpdm_pkg::COS30_Q16);
			ral_s2 <= rot_al;
			rbe_s2 <= rot_be;
			// s3: phases a, b of the command and of the selector
			pa_s3 <= PH_W'(al_s2) <<< 16;
			pb_s3 <= bc_s2 - (PH_W'(al_s2) <<< 15);
			va_s3 <= PH_W'(ral_s2) <<< 16;
			vb_s3 <= PH_W'(rbe_s2) * PH_W'(tpdm_pkg::COS30_Q16) - (PH_W'(ral_s2) <<< 15);
			// s4: phase c closes the sum to zero
			pa_s4 <= pa_s3;
			pb_s4 <= pb_s3;
			pc_s4 <= -pa_s3 - pb_s3;
			va_s4 <= va_s3;
			vb_s4 <= vb_s3;
			vc_s4 <= -va_s3 - vb_s3;
			// s5: extremes
			pa_s5  <= pa_s4;
			pb_s5  <= pb_s4;
			pc_s5  <= pc_s4;
			mx_s5  <= max3(pa_s4, pb_s4, pc_s4);
			mn_s5  <= min3(pa_s4, pb_s4, pc_s4);
			vmx_s5 <= max3(va_s4, vb_s4, vc_s4);
			vmn_s5 <= min3(va_s4, vb_s4, vc_s4);
		end
	end

	// Classification: common-mode offset in Q45 (duty = 2*phase + offset)
	assign mxe     = DUTY_W'(mx_s5);
	assign mne     = DUTY_W'(mn_s5);
	assign sel_sum = (mode == tpdm_pkg::MODE_DPWM1) ? (mxe + mne)
		: (DUTY_W'(vmx_s5) + DUTY_W'(vmn_s5));
	assign ofs_hi  = tpdm_pkg::DUTY_ONE - (mxe <<< 1);
	assign ofs_lo  = DUTY_W'(0) - (mne <<< 1);

	always_comb begin
		unique case (mode)
			tpdm_pkg::MODE_SPWM:      ofs = tpdm_pkg::DUTY_HALF;
			tpdm_pkg::MODE_SVPWM:     ofs = tpdm_pkg::DUTY_HALF - (mxe + mne);
			tpdm_pkg::MODE_CLAMP_MAX: ofs = ofs_hi;
			tpdm_pkg::MODE_CLAMP_MIN: ofs = ofs_lo;
			// discontinuous modes: a tie on the selector clamps max
			default:                  ofs = sel_sum[DUTY_W-1] ? ofs_lo : ofs_hi;
		endcase
	end

	assign job.pa    = pa_s5;
	assign job.pb    = pb_s5;
	assign job.pc    = pc_s5;
	assign job.ofs   = ofs;
	assign job_valid = v_s5;

endmodule

@@ hdl/tpdm_queue.sv @@
`timescale 1ns / 1ps
// tpdm_queue.sv: short FIFO of classified jobs between front and back.
// Depends on tpdm_pkg for the job type.
module tpdm_queue #(
	parameter int DEPTH = 4   // 2 or more
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tpdm_pkg::duty_job_t push_job,
	input  logic                push_valid,
	output logic                push_ready,
	output tpdm_pkg::duty_job_t pop_job,
	output logic                pop_valid,
	input  logic                pop_ready
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tpdm_pkg::duty_job_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_job    = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond depth");

	a_count_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a lone push");

endmodule

@@ hdl/tpdm_back.sv @@
`timescale 1ns / 1ps
// tpdm_back.sv: duty offset, saturation and scaling to timer compare values.
// Depends on tpdm_pkg and tpdm_cmp_if; drains tpdm_queue.
module tpdm_back #(
	parameter int COMPARE_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  tpdm_pkg::duty_job_t      job,
	input  logic                     job_valid,
	output logic                     job_ready,
	input  logic [COMPARE_WIDTH-1:0] period,
	tpdm_cmp_if.source               cmp
);

	localparam int PH_W   = tpdm_pkg::PH_W;
	localparam int DUTY_W = tpdm_pkg::DUTY_W;
	localparam int DSAT_W = tpdm_pkg::DSAT_W;
	localparam int DSPLIT = tpdm_pkg::DSPLIT;
	localparam int DFRAC  = tpdm_pkg::DFRAC;
	localparam int PP_W   = DSAT_W - DSPLIT + COMPARE_WIDTH;
	localparam int ACC_W  = DSAT_W + COMPARE_WIDTH + 1;
	localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (DFRAC - 1);

	logic adv;
	logic v_s1, v_s2, out_valid_q;

	logic signed [PH_W-1:0]   ph [3];
	logic signed [DUTY_W-1:0] dsum [3];
	logic [DSAT_W-1:0]        dsat [3];
	logic                     clip_any;

	logic [DSAT_W-1:0]        duty_s1 [3];
	logic                     clip_s1;
	logic [PP_W-1:0]          hi_s2 [3];
	logic [PP_W-1:0]          lo_s2 [3];
	logic                     clip_s2;
	logic [ACC_W-1:0]         acc [3];
	logic [COMPARE_WIDTH-1:0] cmp_q [3];
	logic                     clipped_q;

	// Output register parts the back from the sink; everything moves when it drains
	assign adv       = !(out_valid_q && !cmp.ready);
	assign job_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= job_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	// Duty = 2*phase + offset, saturated to [0, 1]
	always_comb begin
		ph[0]    = job.pa;
		ph[1]    = job.pb;
		ph[2]    = job.pc;
		clip_any = 1'b0;
		for (int i = 0; i < 3; i++) begin
			dsum[i] = (DUTY_W'(ph[i]) <<< 1) + job.ofs;
			if (dsum[i][DUTY_W-1]) begin
				dsat[i]  = '0;
				clip_any = 1'b1;
			end else if (dsum[i] > tpdm_pkg::DUTY_ONE) begin
				dsat[i]  = tpdm_pkg::DSAT_ONE;
				clip_any = 1'b1;
			end else begin
				dsat[i]  = dsum[i][DSAT_W-1:0];
			end
		end
	end

	// Scaled compare: (hi*P << split) + lo*P, rounded half up at the duty's point
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc[i] = (ACC_W'(hi_s2[i]) << DSPLIT) + ACC_W'(lo_s2[i]) + RND;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			clip_s1   <= clip_any;
			clip_s2   <= clip_s1;
			clipped_q <= clip_s2;
			for (int i = 0; i < 3; i++) begin
				duty_s1[i] <= dsat[i];
				hi_s2[i]   <= PP_W'(duty_s1[i][DSAT_W-1:DSPLIT]) * PP_W'(period);
				lo_s2[i]   <= PP_W'(duty_s1[i][DSPLIT-1:0]) * PP_W'(period);
				cmp_q[i]   <= acc[i][DFRAC +: COMPARE_WIDTH];
			end
		end
	end

	assign cmp.valid     = out_valid_q;
	assign cmp.compare_a = cmp_q[0];
	assign cmp.compare_b = cmp_q[1];
	assign cmp.compare_c = cmp_q[2];
	assign cmp.clipped   = clipped_q;

endmodule
